[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files of this project.
// Each macro takes a label, a clock, an active-low reset and the two sides of an implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VTLRU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VTLRU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[hw/rtl/vtlru_pkg.sv]
// Shared types, codes and constants of the virtual-texture page LRU cache.
// Used by the cell, the cell row, the top level and the checker; depends on nothing.
package vtlru_pkg;

	// Number of cells in the recency row.
	localparam int SLOTS = 64;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Highest legal mip level.
	localparam logic [4:0] MAX_MIP = 5'd30;

	// Command codes carried in the input tuser.
	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_FLUSH   = 1'b1;

	// Status codes of a result beat.
	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_MISS      = 3'd1;
	localparam logic [2:0] ST_NO_LAYERS = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_FLUSH     = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_WIDTH    = 3'd0;
	localparam logic [2:0] REG_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_TILE     = 3'd2;
	localparam logic [2:0] REG_CAPACITY = 3'd3;
	localparam logic [2:0] REG_LAYERS   = 3'd4;

	// Page key held by one cell.
	typedef struct packed {
		logic        attribute;
		logic [4:0]  mip;
		logic [15:0] y;
		logic [15:0] x;
	} page_key_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic      req;
		logic      flush;
		logic      full;
		page_key_t key;
	} chain_ctl_t;

	// Input beat layout, last field in the lowest bits.
	typedef struct packed {
		logic [1:0]  pad;
		logic        attribute;
		logic [4:0]  mip_level;
		logic [15:0] page_y;
		logic [15:0] page_x;
	} in_beat_t;

	// Output beat layout, last field in the lowest bits.
	typedef struct packed {
		logic [6:0]       pad;
		logic [31:0]      eviction_total;
		logic [31:0]      miss_total;
		logic [31:0]      hit_total;
		logic [CNT_W-1:0] resident_count;
		logic             evicted_attribute;
		logic [4:0]       evicted_mip;
		logic [15:0]      evicted_y;
		logic [15:0]      evicted_x;
		logic             evicted;
		logic [2:0]       status;
	} out_beat_t;

endpackage

[hw/rtl/virtual_texture_page_lru_cache_unit.sv]
// Top level of the virtual-texture page LRU cache: configuration, bounds check and result register.
// Depends on vtlru_pkg and vtlru_chain.
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser carries the command
//   (request or flush), s_tdata the page key. Every input beat gives exactly one result beat
//   on m_tvalid/m_tready/m_tdata, in order.
//   An accepted beat and its page bounds, formed with two 16x11 multipliers, are registered
//   in the first stage; the second stage compares the key against all 64 cells of the
//   recency row, moves the row and loads the result register that drives m_tvalid. With
//   m_tready held high a new beat is taken every cycle.
//   While a result waits in the output register the block still takes one more beat into
//   its first stage; it then holds s_tready low until the receiver takes the result.
//   Configuration writes on cfg_we/cfg_index/cfg_data take effect at once and should only
//   be made while no beat is in flight; indexes beyond the register list are ignored.
//   Reset empties the store, clears the counters and loads the register defaults. The store
//   needs no clearing pass: the cell valid bits clear at once.
module virtual_texture_page_lru_cache_unit (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port.
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [16:0]  cfg_data,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,  // page_x, page_y, mip_level, attribute, zero fill
	input  logic [0:0]   s_tuser,  // command
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata   // status, evicted, evicted_x, evicted_y, evicted_mip,
	                               // evicted_attribute, resident_count, hit_total,
	                               // miss_total, eviction_total, zero fill
);

	localparam int CW = vtlru_pkg::CNT_W;

	// Configuration registers.
	logic [16:0]   width_q;
	logic [16:0]   height_q;
	logic [10:0]   tile_q;
	logic [6:0]    cap_q;
	logic [4:0]    layers_q;

	// First stage.
	logic                 v_s1;
	logic                 cmd_s1;
	vtlru_pkg::page_key_t key_s1;
	logic                 mip_bad_s1;
	logic [26:0]          prod_x_s1;
	logic [26:0]          prod_y_s1;
	logic [16:0]          size_w_s1;
	logic [16:0]          size_h_s1;

	// Cache state and result register.
	logic [CW-1:0]        resident_q;
	logic [31:0]          hit_q;
	logic [31:0]          miss_q;
	logic [31:0]          evict_cnt_q;
	logic                 m_tvalid_q;
	vtlru_pkg::out_beat_t out_q;

	vtlru_pkg::in_beat_t   in_beat;
	logic                  accept;
	logic                  adv;
	logic [10:0]           tile_eff;
	logic [16:0]           w_shift;
	logic [16:0]           h_shift;
	logic                  is_flush;
	logic                  range_err;
	logic                  req;
	logic [CW-1:0]         cap_eff;
	logic                  full;
	logic                  found;
	logic                  evict_now;
	vtlru_pkg::page_key_t  evict_key;
	vtlru_pkg::chain_ctl_t ctl;
	logic [2:0]            status;
	logic [CW-1:0]         resident_next;

	assign in_beat = vtlru_pkg::in_beat_t'(s_tdata);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 17'd1024;
			height_q <= 17'd1024;
			tile_q   <= 11'd128;
			cap_q    <= 7'd64;
			layers_q <= 5'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				vtlru_pkg::REG_WIDTH:    width_q  <= cfg_data;
				vtlru_pkg::REG_HEIGHT:   height_q <= cfg_data;
				vtlru_pkg::REG_TILE:     tile_q   <= cfg_data[10:0];
				vtlru_pkg::REG_CAPACITY: cap_q    <= cfg_data[6:0];
				vtlru_pkg::REG_LAYERS:   layers_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage one advances when the result register is free or being emptied.
	assign adv      = v_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// Bounds terms: a coordinate is out of range when coord * tile >= max(1, size >> mip).
	assign tile_eff = (tile_q == 11'd0) ? 11'd1 : tile_q;
	assign w_shift  = width_q >> in_beat.mip_level;
	assign h_shift  = height_q >> in_beat.mip_level;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1         <= s_tuser[0];
			key_s1.x       <= in_beat.page_x;
			key_s1.y       <= in_beat.page_y;
			key_s1.mip     <= in_beat.mip_level;
			key_s1.attribute <= in_beat.attribute;
			mip_bad_s1     <= in_beat.mip_level > vtlru_pkg::MAX_MIP;
			prod_x_s1      <= 27'(in_beat.page_x) * 27'(tile_eff);
			prod_y_s1      <= 27'(in_beat.page_y) * 27'(tile_eff);
			size_w_s1      <= (w_shift == 17'd0) ? 17'd1 : w_shift;
			size_h_s1      <= (h_shift == 17'd0) ? 17'd1 : h_shift;
		end
	end

	// Second stage: classify the beat and drive the cell row.
	assign is_flush  = cmd_s1 == vtlru_pkg::CMD_FLUSH;
	assign range_err = mip_bad_s1 || (prod_x_s1 >= 27'(size_w_s1))
	                   || (prod_y_s1 >= 27'(size_h_s1));
	assign req       = adv && !is_flush && (layers_q != 5'd0) && !range_err;

	// Capacity of zero acts as one; anything above the row length is clamped.
	always_comb begin
		if (cap_q == 7'd0) begin
			cap_eff = CW'(1);
		end else if (CW'(cap_q) > CW'(vtlru_pkg::SLOTS)) begin
			cap_eff = CW'(vtlru_pkg::SLOTS);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end
	assign full = resident_q >= cap_eff;

	assign ctl.req   = req;
	assign ctl.flush = adv && is_flush;
	assign ctl.full  = full;
	assign ctl.key   = key_s1;

	vtlru_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.found     (found),
		.evict_key (evict_key)
	);

	assign evict_now = req && !found && full;

	// Status and resident count after this beat.
	always_comb begin
		resident_next = resident_q;
		if (is_flush) begin
			status        = vtlru_pkg::ST_FLUSH;
			resident_next = '0;
		end else if (layers_q == 5'd0) begin
			status = vtlru_pkg::ST_NO_LAYERS;
		end else if (range_err) begin
			status = vtlru_pkg::ST_RANGE;
		end else if (found) begin
			status = vtlru_pkg::ST_HIT;
		end else begin
			status = vtlru_pkg::ST_MISS;
			if (!full) begin
				resident_next = resident_q + CW'(1);
			end
		end
	end

	// Resident count and running counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_q  <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			evict_cnt_q <= '0;
		end else if (adv) begin
			resident_q <= resident_next;
			if (req && found) begin
				hit_q <= hit_q + 32'd1;
			end
			if (req && !found) begin
				miss_q <= miss_q + 32'd1;
			end
			if (evict_now) begin
				evict_cnt_q <= evict_cnt_q + 32'd1;
			end
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result register payload; counters shown include this beat.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.pad               <= '0;
			out_q.status            <= status;
			out_q.evicted           <= evict_now;
			out_q.evicted_x         <= evict_now ? evict_key.x : 16'd0;
			out_q.evicted_y         <= evict_now ? evict_key.y : 16'd0;
			out_q.evicted_mip       <= evict_now ? evict_key.mip : 5'd0;
			out_q.evicted_attribute <= evict_now ? evict_key.attribute : 1'b0;
			out_q.resident_count    <= resident_next;
			out_q.hit_total         <= (req && found) ? hit_q + 32'd1 : hit_q;
			out_q.miss_total        <= (req && !found) ? miss_q + 32'd1 : miss_q;
			out_q.eviction_total    <= evict_now ? evict_cnt_q + 32'd1 : evict_cnt_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

[hw/rtl/vtlru_cell.sv]
// One recency cell: a valid bit and a page key, ordered by position in the row.
// Depends on vtlru_pkg for the key and control types.
module vtlru_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vtlru_pkg::chain_ctl_t  ctl,
	input  logic                   found,
	input  vtlru_pkg::page_key_t   left_key,
	input  logic                   left_valid,
	input  logic                   right_valid,
	input  logic                   hit_in,
	output logic                   hit_out,
	input  vtlru_pkg::page_key_t   evict_in,
	output vtlru_pkg::page_key_t   evict_out,
	output vtlru_pkg::page_key_t   key,
	output logic                   valid
);

	logic                 valid_q;
	vtlru_pkg::page_key_t key_q;
	logic                 match;
	logic                 tail;
	logic                 left_tail;
	logic                 shift;
	logic                 evict_now;

	// Tag compare and hit flag handed down the row.
	assign match   = valid_q && (key_q == ctl.key);
	assign hit_out = hit_in | match;

	// The tail cell is the least recent one and drives its key onto the eviction bus.
	assign tail      = valid_q && !right_valid;
	assign left_tail = left_valid && !valid_q;
	assign evict_out = tail ? (evict_in | key_q) : evict_in;

	// On a miss the whole row moves down; on a hit only the cells up to the hit.
	assign shift     = ctl.req && (!found || !hit_in);
	assign evict_now = ctl.req && !found && ctl.full;

	// Valid bit: the copy of the old tail is dropped when a page is evicted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.flush) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= left_valid && !(evict_now && left_tail);
		end
	end

	// Key register.
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= left_key;
		end
	end

	assign key   = key_q;
	assign valid = valid_q;

endmodule

[hw/rtl/vtlru_chain.sv]
// Row of recency cells, most recent page in cell zero, least recent at the tail.
// Depends on vtlru_pkg and vtlru_cell.
module vtlru_chain (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vtlru_pkg::chain_ctl_t ctl,
	output logic                  found,
	output vtlru_pkg::page_key_t  evict_key
);

	localparam int N = vtlru_pkg::SLOTS;

	vtlru_pkg::page_key_t key_lnk   [N];
	logic                 valid_lnk [N];
	logic                 hit_lnk   [N+1];
	vtlru_pkg::page_key_t evict_lnk [N+1];

	assign hit_lnk[0]   = 1'b0;
	assign evict_lnk[0] = '0;

	// Each cell takes its left neighbor's entry; cell zero takes the requested key.
	for (genvar i = 0; i < N; i++) begin : g_cell
		vtlru_pkg::page_key_t left_key;
		logic                 left_valid;
		logic                 right_valid;

		if (i == 0) begin : g_head
			assign left_key   = ctl.key;
			assign left_valid = 1'b1;
		end else begin : g_body
			assign left_key   = key_lnk[i-1];
			assign left_valid = valid_lnk[i-1];
		end

		if (i == N - 1) begin : g_end
			assign right_valid = 1'b0;
		end else begin : g_mid
			assign right_valid = valid_lnk[i+1];
		end

		vtlru_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.found       (found),
			.left_key    (left_key),
			.left_valid  (left_valid),
			.right_valid (right_valid),
			.hit_in      (hit_lnk[i]),
			.hit_out     (hit_lnk[i+1]),
			.evict_in    (evict_lnk[i]),
			.evict_out   (evict_lnk[i+1]),
			.key         (key_lnk[i]),
			.valid       (valid_lnk[i])
		);
	end

	assign found     = hit_lnk[N];
	assign evict_key = evict_lnk[N];

endmodule

[hw/rtl/vtlru_checker.sv]
// Port-level checks of the virtual-texture page LRU cache, bound to its top level.
// Depends on vtlru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vtlru_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [151:0] m_tdata
);

	logic [2:0] status;
	logic       evicted;
	logic [6:0] resident;
	logic       flush_beat;
	logic       evict_beat;

	assign status     = m_tdata[2:0];
	assign evicted    = m_tdata[3];
	assign resident   = m_tdata[48:42];
	assign flush_beat = m_tvalid && (status == vtlru_pkg::ST_FLUSH);
	assign evict_beat = m_tvalid && evicted;

	// A stalled result beat keeps its payload.
	`VTLRU_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// Only a miss may report an eviction.
	`VTLRU_ASSERT_IMPLY(a_evict_miss, clk, arst_n, evict_beat, status == vtlru_pkg::ST_MISS)

	// A flush always leaves the store empty.
	`VTLRU_ASSERT_IMPLY(a_flush_empty, clk, arst_n, flush_beat, resident == 7'd0)

	// The resident count never exceeds the row length.
	`VTLRU_ASSERT_IMPLY(a_count_max, clk, arst_n, m_tvalid, resident <= 7'(vtlru_pkg::SLOTS))

	// The input is held off only behind a result beat that the receiver is stalling.
	`VTLRU_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready)

endmodule

bind virtual_texture_page_lru_cache_unit vtlru_checker u_vtlru_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[tb/sv/virtual_texture_page_lru_cache_unit_tb.sv]
// Self-checking testbench for the virtual-texture page LRU cache unit.
// Drives page requests and flushes through the input stream and checks every result beat
// against an in-bench LRU page store; depends on vtlru_pkg and the top-level RTL.
module virtual_texture_page_lru_cache_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 200;

	typedef struct {
		logic                 cmd;
		vtlru_pkg::page_key_t key;
	} page_command_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [16:0]  cfg_data  = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [39:0]  s_tdata   = '0;  // page_x, page_y, mip_level, attribute, zero fill
	logic [0:0]   s_tuser   = '0;  // command
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [151:0] m_tdata;         // status, evicted, evicted_x, evicted_y, evicted_mip,
	                               // evicted_attribute, resident_count, hit_total,
	                               // miss_total, eviction_total, zero fill

	// Register copies, loaded with the reset defaults.
	logic [16:0] width_cfg    = 17'd1024;
	logic [16:0] height_cfg   = 17'd1024;
	logic [10:0] tile_cfg     = 11'd128;
	logic [6:0]  capacity_cfg = 7'd64;
	logic [4:0]  layers_cfg   = 5'd0;

	// Resident pages, most recent first, and the wrapping counters.
	vtlru_pkg::page_key_t resident_keys[$];
	logic [31:0] hit_tally      = '0;
	logic [31:0] miss_tally     = '0;
	logic [31:0] eviction_tally = '0;
	int unsigned status_tally[5];

	page_command_t        pending_cmds[$];
	vtlru_pkg::out_beat_t expected_results[$];
	vtlru_pkg::page_key_t key_pool[$];

	int unsigned items_submitted = 0;
	int unsigned items_accepted  = 0;
	int unsigned results_seen    = 0;
	int unsigned mismatch_count  = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned send_idle_pct   = 0;
	int unsigned recv_idle_pct   = 0;
	bit          hold_off_go     = 1'b0;
	bit          hold_off_used   = 1'b0;
	int unsigned hold_off_left   = 0;

	page_command_t        offered;
	vtlru_pkg::in_beat_t  beat_word;
	vtlru_pkg::out_beat_t predicted;
	vtlru_pkg::out_beat_t got;
	vtlru_pkg::out_beat_t want;

	virtual_texture_page_lru_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Free-running 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Number of pages along one axis at a given mip; zero sizes count as one.
	function automatic int unsigned pages_along_axis(input int unsigned extent,
			input int unsigned mip);
		int unsigned tile;
		int unsigned span;
		tile = (tile_cfg == '0) ? 1 : int'(tile_cfg);
		span = extent >> mip;
		if (span < 1) span = 1;
		return (span + tile - 1) / tile;
	endfunction

	// Applies one command to the page store and returns the result beat it should give.
	function automatic vtlru_pkg::out_beat_t serve_page_command(input logic cmd,
			input vtlru_pkg::page_key_t key);
		vtlru_pkg::out_beat_t r;
		vtlru_pkg::page_key_t victim;
		int                   hit_pos;
		int unsigned          cap;
		r = '0;
		if (cmd == vtlru_pkg::CMD_FLUSH) begin
			resident_keys.delete();
			r.status = vtlru_pkg::ST_FLUSH;
		end else if (layers_cfg == '0) begin
			r.status = vtlru_pkg::ST_NO_LAYERS;
		end else if (key.mip > vtlru_pkg::MAX_MIP
				|| 32'(key.x) >= pages_along_axis(32'(width_cfg), 32'(key.mip))
				|| 32'(key.y) >= pages_along_axis(32'(height_cfg), 32'(key.mip))) begin
			r.status = vtlru_pkg::ST_RANGE;
		end else begin
			hit_pos = -1;
			foreach (resident_keys[i])
				if (hit_pos < 0 && resident_keys[i] == key) hit_pos = i;
			if (hit_pos >= 0) begin
				resident_keys.delete(hit_pos);
				resident_keys = {key, resident_keys};
				hit_tally++;
				r.status = vtlru_pkg::ST_HIT;
			end else begin
				miss_tally++;
				r.status = vtlru_pkg::ST_MISS;
				cap = (capacity_cfg == '0) ? 1 : int'(capacity_cfg);
				if (cap > vtlru_pkg::SLOTS) cap = vtlru_pkg::SLOTS;
				// Evict the least recent page once the store is at or over capacity.
				if (resident_keys.size() >= cap && resident_keys.size() > 0) begin
					victim = resident_keys[$];
					resident_keys.delete(resident_keys.size() - 1);
					r.evicted           = 1'b1;
					r.evicted_x         = victim.x;
					r.evicted_y         = victim.y;
					r.evicted_mip       = victim.mip;
					r.evicted_attribute = victim.attribute;
					eviction_tally++;
				end
				resident_keys = {key, resident_keys};
			end
		end
		r.resident_count = vtlru_pkg::CNT_W'(resident_keys.size());
		r.hit_total      = hit_tally;
		r.miss_total     = miss_tally;
		r.eviction_total = eviction_tally;
		status_tally[r.status]++;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] result %0d: %s", $time, results_seen, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] seen,
			input logic [31:0] due);
		if (seen !== due)
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, due));
	endtask

	function automatic vtlru_pkg::page_key_t make_key(input logic [15:0] x,
			input logic [15:0] y, input logic [4:0] mip, input logic attr);
		vtlru_pkg::page_key_t k;
		k.x         = x;
		k.y         = y;
		k.mip       = mip;
		k.attribute = attr;
		return k;
	endfunction

	function automatic void queue_command(input logic cmd, input vtlru_pkg::page_key_t key);
		page_command_t c;
		c.cmd = cmd;
		c.key = key;
		pending_cmds = {pending_cmds, c};
		items_submitted++;
	endfunction

	// A key that is in range for the current geometry, mostly at the finer mips.
	function automatic vtlru_pkg::page_key_t fresh_page_key();
		logic [4:0]  mip;
		int unsigned cols;
		int unsigned rows;
		mip  = ($urandom_range(99) < 75) ? 5'($urandom_range(3)) : 5'($urandom_range(30));
		cols = pages_along_axis(32'(width_cfg), 32'(mip));
		rows = pages_along_axis(32'(height_cfg), 32'(mip));
		if (cols > 65536) cols = 65536;
		if (rows > 65536) rows = 65536;
		return make_key(16'($urandom_range(cols - 1)), 16'($urandom_range(rows - 1)), mip,
			1'($urandom_range(1)));
	endfunction

	// Mostly repeats from a small working set so hits and evictions are frequent;
	// the rest is new pages, flushes and unconstrained noise.
	task automatic queue_random_traffic(input int count, input int pool_size,
			input int flush_pct);
		int                   pick;
		vtlru_pkg::page_key_t k;
		key_pool.delete();
		repeat (pool_size) key_pool = {key_pool, fresh_page_key()};
		repeat (count) begin
			pick = int'($urandom_range(99));
			if (pick < flush_pct) begin
				queue_command(vtlru_pkg::CMD_FLUSH, make_key(16'($urandom), 16'($urandom),
					5'($urandom_range(31)), 1'($urandom_range(1))));
			end else if (pick < flush_pct + 8) begin
				queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'($urandom), 16'($urandom),
					5'($urandom_range(31)), 1'($urandom_range(1))));
			end else if (pick < flush_pct + 18) begin
				k = fresh_page_key();
				key_pool[$urandom_range(pool_size - 1)] = k;
				queue_command(vtlru_pkg::CMD_REQUEST, k);
			end else begin
				queue_command(vtlru_pkg::CMD_REQUEST, key_pool[$urandom_range(pool_size - 1)]);
			end
		end
	endtask

	// Registers are written only with nothing in flight.
	task automatic write_register(input logic [2:0] idx, input logic [16:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			vtlru_pkg::REG_WIDTH:    width_cfg    = value;
			vtlru_pkg::REG_HEIGHT:   height_cfg   = value;
			vtlru_pkg::REG_TILE:     tile_cfg     = value[10:0];
			vtlru_pkg::REG_CAPACITY: capacity_cfg = value[6:0];
			vtlru_pkg::REG_LAYERS:   layers_cfg   = value[4:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Holds the sender back until every queued command has its result, then lets the
	// pipeline settle.
	task automatic wait_for_idle();
		do @(posedge clk);
		while (items_accepted != items_submitted || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input driver: predicts each accepted beat and offers the next pending command.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted = serve_page_command(offered.cmd, offered.key);
				expected_results = {expected_results, predicted};
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered             = pending_cmds.pop_front();
					beat_word           = '0;
					beat_word.page_x    = offered.key.x;
					beat_word.page_y    = offered.key.y;
					beat_word.mip_level = offered.key.mip;
					beat_word.attribute = offered.key.attribute;
					s_tdata  <= beat_word;
					s_tuser  <= offered.cmd;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result beat against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = vtlru_pkg::out_beat_t'(m_tdata);
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with no command outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(got.status), 32'(want.status));
					check_field("evicted", 32'(got.evicted), 32'(want.evicted));
					check_field("evicted_x", 32'(got.evicted_x), 32'(want.evicted_x));
					check_field("evicted_y", 32'(got.evicted_y), 32'(want.evicted_y));
					check_field("evicted_mip", 32'(got.evicted_mip), 32'(want.evicted_mip));
					check_field("evicted_attribute", 32'(got.evicted_attribute),
						32'(want.evicted_attribute));
					check_field("resident_count", 32'(got.resident_count),
						32'(want.resident_count));
					check_field("hit_total", got.hit_total, want.hit_total);
					check_field("miss_total", got.miss_total, want.miss_total);
					check_field("eviction_total", got.eviction_total, want.eviction_total);
				end
			end
			// One long hold-off on request, otherwise random back-pressure.
			if (hold_off_go && !hold_off_used) begin
				hold_off_used = 1'b1;
				hold_off_left = HOLD_OFF_CYCLES;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles in which no beat moves.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles", quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus sequence: directed corner cases, then three random phases.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 16;
		recv_idle_pct = 79;

		// Reset defaults have no layers, so every request is refused before the range check.
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'h0000, 16'h0000, 5'd0, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'hFFFF, 16'hFFFF, 5'd31, 1'b1));
		queue_command(vtlru_pkg::CMD_FLUSH, make_key(16'h1234, 16'h5678, 5'd3, 1'b1));
		wait_for_idle();

		// Zero width, height, tile and capacity: one page per mip and a single slot.
		write_register(vtlru_pkg::REG_WIDTH, 17'd0);
		write_register(vtlru_pkg::REG_HEIGHT, 17'd0);
		write_register(vtlru_pkg::REG_TILE, 17'd0);
		write_register(vtlru_pkg::REG_CAPACITY, 17'd0);
		write_register(vtlru_pkg::REG_LAYERS, 17'd1);
		for (int idx = int'(vtlru_pkg::REG_LAYERS) + 1; idx < 8; idx++)
			write_register(3'(idx), 17'h1FFFF);
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd0, 5'd0, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd0, 5'd0, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd0, 5'd0, 1'b1));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd0, 5'd30, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd0, 5'd31, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd1, 16'd0, 5'd0, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd1, 5'd5, 1'b1));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'hFFFF, 16'hFFFF, 5'd31, 1'b1));
		queue_command(vtlru_pkg::CMD_FLUSH, make_key(16'd0, 16'd0, 5'd0, 1'b0));
		wait_for_idle();

		// Largest width and tile, height of 65536, capacity above the slot count, all layer bits set.
		write_register(vtlru_pkg::REG_WIDTH, 17'h1FFFF);
		write_register(vtlru_pkg::REG_HEIGHT, 17'd65536);
		write_register(vtlru_pkg::REG_TILE, 17'd2047);
		write_register(vtlru_pkg::REG_CAPACITY, 17'd127);
		write_register(vtlru_pkg::REG_LAYERS, 17'd31);
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd64, 16'd32, 5'd0, 1'b1));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd65, 16'd0, 5'd0, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd33, 5'd0, 1'b0));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd0, 16'd0, 5'd30, 1'b1));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd64, 16'd32, 5'd0, 1'b1));
		queue_command(vtlru_pkg::CMD_FLUSH, make_key(16'hFFFF, 16'hFFFF, 5'd31, 1'b1));
		queue_command(vtlru_pkg::CMD_REQUEST, make_key(16'd64, 16'd32, 5'd0, 1'b1));
		wait_for_idle();

		// Small store under heavy back-pressure, left well filled at the end.
		write_register(vtlru_pkg::REG_WIDTH, 17'd1024);
		write_register(vtlru_pkg::REG_HEIGHT, 17'd512);
		write_register(vtlru_pkg::REG_TILE, 17'd128);
		write_register(vtlru_pkg::REG_CAPACITY, 17'd8);
		write_register(vtlru_pkg::REG_LAYERS, 17'd3);
		queue_random_traffic(130, 12, 4);
		repeat (10) queue_command(vtlru_pkg::CMD_REQUEST, fresh_page_key());
		wait_for_idle();

		// Capacity dropped below the resident count; the sender is now the slow side.
		send_idle_pct = 79;
		recv_idle_pct = 16;
		write_register(vtlru_pkg::REG_WIDTH, 17'd4096);
		write_register(vtlru_pkg::REG_HEIGHT, 17'd4096);
		write_register(vtlru_pkg::REG_TILE, 17'd64);
		write_register(vtlru_pkg::REG_CAPACITY, 17'd2);
		write_register(vtlru_pkg::REG_LAYERS, 17'd16);
		queue_random_traffic(65, 5, 4);
		wait_for_idle();
		queue_random_traffic(65, 5, 4);
		wait_for_idle();

		// Full-size store at full rate, opened by one long receiver hold-off.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_register(vtlru_pkg::REG_WIDTH, 17'd65536);
		write_register(vtlru_pkg::REG_HEIGHT, 17'd65536);
		write_register(vtlru_pkg::REG_TILE, 17'd1024);
		write_register(vtlru_pkg::REG_CAPACITY, 17'd64);
		write_register(vtlru_pkg::REG_LAYERS, 17'd1);
		hold_off_go = 1'b1;
		queue_random_traffic(160, 80, 0);
		wait_for_idle();

		$display("Ran %0d commands through %0d result beats under six register settings.",
			items_accepted, results_seen);
		$display("Outcomes: %0d hits, %0d misses, %0d evictions, %0d refused, %0d flushes.",
			status_tally[vtlru_pkg::ST_HIT], status_tally[vtlru_pkg::ST_MISS], eviction_tally,
			status_tally[vtlru_pkg::ST_NO_LAYERS] + status_tally[vtlru_pkg::ST_RANGE],
			status_tally[vtlru_pkg::ST_FLUSH]);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
